// ===== design/jdm_pkg.sv =====
// ----------------------------------------------------------------------------
// jdm_pkg - shared types and constants for the joystick drive mixer
// Stick thresholds, divisors, direction codes and sequencer encodings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jdm_pkg;

   // Stick thresholds and spans
   localparam logic [11:0] HI_EDGE    = 12'd2500;
   localparam logic [11:0] LO_EDGE    = 12'd1500;
   localparam logic [12:0] TURN_TOP   = 13'd4100;
   localparam logic [10:0] HI_SPAN    = 11'd1600;
   localparam logic [10:0] LO_SPAN    = 11'd1500;
   localparam logic [9:0]  FULL_SCALE = 10'd1000;

   // Motor direction codes
   localparam logic [3:0] DIR_FORWARD    = 4'h0;
   localparam logic [3:0] DIR_REVERSE    = 4'hF;
   localparam logic [3:0] DIR_SPIN_RIGHT = 4'hC;
   localparam logic [3:0] DIR_SPIN_LEFT  = 4'h3;

   // Arithmetic widths: operand, multiplier digit count, product, quotient
   localparam int OPND_W = 11;
   localparam int MULT_W = 10;
   localparam int PROD_W = 21;
   localparam int QUO_W  = 10;
   localparam logic [3:0] STEP_LAST = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      JOB_LIM,
      JOB_LEFT,
      JOB_RIGHT
   } job_type;

endpackage

// ===== design/joystick_drive_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_drive_mixer_unit - tank drive mixer for two joystick samples
// Bit-serial multiply and shift-subtract divide compute every speed ratio.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one (speed, turn) pair of 12-bit samples per transfer.
//   Result channel rsp_*: one transfer per input, carrying the four-bit motor
//   direction mask and the left and right speeds (0..1000).
//   Each ratio floor(a * b / d) runs on one shared unit: after a load step, a
//   serial multiply of one multiplier bit per cycle, then a restoring divide
//   giving one quotient bit per cycle.
//   Both sticks centred skip the arithmetic; one ratio is computed for
//   straight drive or spin in place, and three ratios with speed and turn
//   both deflected. The next input is taken in the cycle after the result
//   is written to the output register.
//   The output register holds a finished result while the receiver stalls;
//   the block keeps accepting new input and stops only when a second result
//   is ready to be written.
//   Reset clears the sequencer, the output valid flag and the kept direction
//   mask (forward).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_drive_mixer_unit
   import jdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_speed_sample,
   input  logic [11:0] req_turn_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_drive_direction,
   output logic [9:0]  rsp_left_speed,
   output logic [9:0]  rsp_right_speed
);

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   logic              start;
   logic              load_out;
   logic              div_last;
   logic              div_take;

   // Decoded sticks
   logic              s_hi, s_lo, s_act, t_hi, t_lo;
   logic [11:0]       s_up, s_dn, t_up, t_dn;
   logic [12:0]       t_rev;

   // Item context
   logic [OPND_W-1:0] sx_ff, sx_in;
   logic              sdiv_hi_ff, sdiv_hi_in;
   logic [OPND_W-1:0] lx_ff, lx_in;
   logic              ldiv_hi_ff, ldiv_hi_in;
   logic              need_lim_ff, need_lim_in;
   logic              turn_hi_ff, turn_hi_in;
   logic [3:0]        dir_ff, dir_in;
   logic [QUO_W-1:0]  lim_ff, lim_in;
   logic [QUO_W-1:0]  left_ff, left_in;
   logic [QUO_W-1:0]  right_ff, right_in;

   // Shared multiply / divide unit
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [MULT_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [PROD_W-1:0] acc_diff;

   // Job operands
   logic [OPND_W-1:0] job_x;
   logic [MULT_W-1:0] job_m;
   logic              job_dhi;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_dir_ff, rsp_dir_in;
   logic [9:0]        rsp_left_ff, rsp_left_in;
   logic [9:0]        rsp_right_ff, rsp_right_in;

   // Decode stick positions
   assign s_hi  = req_speed_sample >= HI_EDGE;
   assign s_lo  = req_speed_sample <= LO_EDGE;
   assign s_act = s_hi || s_lo;
   assign t_hi  = req_turn_sample >= HI_EDGE;
   assign t_lo  = req_turn_sample <= LO_EDGE;
   assign s_up  = req_speed_sample - HI_EDGE;
   assign s_dn  = LO_EDGE - req_speed_sample;
   assign t_up  = req_turn_sample - HI_EDGE;
   assign t_dn  = LO_EDGE - req_turn_sample;
   assign t_rev = TURN_TOP - {1'b0, req_turn_sample};

   // Pick the operands of the current job
   always_comb begin
      job_x   = sx_ff;
      job_m   = FULL_SCALE;
      job_dhi = sdiv_hi_ff;
      case (job_ff)
         JOB_LIM: begin
            job_x   = lx_ff;
            job_dhi = ldiv_hi_ff;
         end
         JOB_LEFT: begin
            if (need_lim_ff && !turn_hi_ff) job_m = lim_ff;
         end
         JOB_RIGHT: begin
            if (need_lim_ff && turn_hi_ff) job_m = lim_ff;
         end
         default: begin
            job_x = sx_ff;
         end
      endcase
   end

   assign div_last = cnt_ff == STEP_LAST;
   assign acc_diff = acc_ff - dsh_ff;
   assign div_take = acc_ff >= dsh_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = (s_act || t_hi || t_lo) ? ST_LOAD : ST_DONE;
         end
         ST_LOAD: state_in = ST_MUL;
         ST_MUL: begin
            if (cnt_ff == STEP_LAST) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) begin
               if (job_ff == JOB_LIM || (job_ff == JOB_LEFT && need_lim_ff)) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = state_ff == ST_IDLE;
      start     = req_valid && (state_ff == ST_IDLE);
      load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // Datapath next values
   always_comb begin
      sx_in        = sx_ff;
      sdiv_hi_in   = sdiv_hi_ff;
      lx_in        = lx_ff;
      ldiv_hi_in   = ldiv_hi_ff;
      need_lim_in  = need_lim_ff;
      turn_hi_in   = turn_hi_ff;
      dir_in       = dir_ff;
      lim_in       = lim_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      job_in       = job_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dir_in   = rsp_dir_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      case (state_ff)
         // Capture the item and plan its jobs
         ST_IDLE: begin
            if (start) begin
               if (s_act) begin
                  sx_in      = s_hi ? s_up[OPND_W-1:0] : s_dn[OPND_W-1:0];
                  sdiv_hi_in = s_hi;
                  dir_in     = s_hi ? DIR_FORWARD : DIR_REVERSE;
               end else begin
                  sx_in      = t_hi ? t_up[OPND_W-1:0] : t_dn[OPND_W-1:0];
                  sdiv_hi_in = t_hi;
                  if (t_hi) dir_in = DIR_SPIN_RIGHT;
                  else if (t_lo) dir_in = DIR_SPIN_LEFT;
               end
               lx_in       = t_hi ? t_rev[OPND_W-1:0] : req_turn_sample[OPND_W-1:0];
               ldiv_hi_in  = t_hi;
               turn_hi_in  = t_hi;
               need_lim_in = s_act && (t_hi || t_lo);
               job_in      = (s_act && (t_hi || t_lo)) ? JOB_LIM : JOB_LEFT;
               left_in     = '0;
               right_in    = '0;
            end
         end
         // Load the shared unit for the current job
         ST_LOAD: begin
            mcand_in  = PROD_W'(job_x);
            mplier_in = job_m;
            acc_in    = '0;
            quo_in    = '0;
            cnt_in    = '0;
            dsh_in    = job_dhi ? PROD_W'({HI_SPAN, 9'd0}) : PROD_W'({LO_SPAN, 9'd0});
         end
         // Add one multiplier bit per cycle
         ST_MUL: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MULT_W-1:1]};
            cnt_in    = (cnt_ff == STEP_LAST) ? 4'd0 : cnt_ff + 4'd1;
         end
         // Retire one quotient bit per cycle
         ST_DIV: begin
            if (div_take) acc_in = acc_diff;
            quo_in = {quo_ff[QUO_W-2:0], div_take};
            dsh_in = {1'b0, dsh_ff[PROD_W-1:1]};
            cnt_in = cnt_ff + 4'd1;
            if (div_last) begin
               case (job_ff)
                  JOB_LIM: begin
                     lim_in = {quo_ff[QUO_W-2:0], div_take};
                     job_in = JOB_LEFT;
                  end
                  JOB_LEFT: begin
                     left_in = {quo_ff[QUO_W-2:0], div_take};
                     if (need_lim_ff) job_in = JOB_RIGHT;
                     else right_in = {quo_ff[QUO_W-2:0], div_take};
                  end
                  JOB_RIGHT: right_in = {quo_ff[QUO_W-2:0], div_take};
                  default: job_in = JOB_LEFT;
               endcase
            end
         end
         // Hand the result to the output register
         ST_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_dir_in   = dir_ff;
               rsp_left_in  = left_ff;
               rsp_right_in = right_ff;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_LEFT;
         dir_ff       <= DIR_FORWARD;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sx_ff        <= sx_in;
      sdiv_hi_ff   <= sdiv_hi_in;
      lx_ff        <= lx_in;
      ldiv_hi_ff   <= ldiv_hi_in;
      need_lim_ff  <= need_lim_in;
      turn_hi_ff   <= turn_hi_in;
      lim_ff       <= lim_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      acc_ff       <= acc_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_direction = rsp_dir_ff;
   assign rsp_left_speed      = rsp_left_ff;
   assign rsp_right_speed     = rsp_right_ff;

   // Without a turn limit only the left job runs
   a_single_job : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_DONE && !need_lim_ff) |-> job_ff == JOB_LEFT)
      else $error("turn limit job scheduled without a turn limit");

   // Finished speeds stay within full scale
   a_speed_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (left_ff <= FULL_SCALE && right_ff <= FULL_SCALE))
      else $error("speed result above full scale");

   // Both sticks centred skips the arithmetic unit
   a_centred_fast : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_speed_sample > LO_EDGE && req_speed_sample < HI_EDGE
       && req_turn_sample > LO_EDGE && req_turn_sample < HI_EDGE)
      |=> (state_ff == ST_DONE && left_ff == '0 && right_ff == '0))
      else $error("centred sticks did not give zero speeds at once");

   // A result is written only into a free or draining output register
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !load_out)
      else $error("output register overwritten while stalled");

endmodule
